FILE: rtl/ccpt_pkg.sv
// ----------------------------------------------------------------------------
// ccpt_pkg
// Shared types and defaults for the circle center from point triples block.
// ----------------------------------------------------------------------------
package ccpt_pkg;

  localparam int TRIPLES_DEF     = 3;
  localparam int COORD_WIDTH_DEF = 24;

  // status of the triple queue seen by its neighbors
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_DPOST,
    ST_ACC,
    ST_OUT
  } back_state_t;

  // products in the order they are formed
  typedef enum logic [3:0] {
    MS_BXBX,
    MS_BZBZ,
    MS_CXCX,
    MS_CZCZ,
    MS_CZBX,
    MS_CXBZ,
    MS_CZB2,
    MS_BZC2,
    MS_BXC2,
    MS_CXB2
  } mul_step_t;

  typedef enum logic [2:0] {
    DS_CX,
    DS_CZ,
    DS_AX,
    DS_AZ,
    DS_AY
  } div_step_t;

endpackage

FILE: rtl/ccpt_front.sv
// ----------------------------------------------------------------------------
// ccpt_front
// Takes points, holds the first two of each triple and pushes whole triples.
// ----------------------------------------------------------------------------
module ccpt_front #(
  parameter int W  = 24,
  parameter int QW = 7 * W + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [W-1:0]           point_x,
  input  logic [W-1:0]           point_y,
  input  logic [W-1:0]           point_z,
  input  ccpt_pkg::queue_status_t qstat,
  output logic                   q_push,
  output logic [QW-1:0]          q_data
);
  import ccpt_pkg::*;

  logic [1:0]   slot;
  logic [W-1:0] x0, z0, x1, z1;
  logic [W:0]   ypart;
  logic [W+1:0] ysum;
  logic         take;

  assign in_stall = (slot == 2'd2) && qstat.full;
  assign take     = in_valid && !in_stall;
  assign q_push   = take && (slot == 2'd2);
  assign ysum     = {ypart[W], ypart} + {{2{point_y[W-1]}}, point_y};
  assign q_data   = {x0, z0, x1, z1, point_x, point_z, ysum};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else if (take) begin
      slot <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (slot == 2'd0) begin
        x0    <= point_x;
        z0    <= point_z;
        ypart <= {point_y[W-1], point_y};
      end else if (slot == 2'd1) begin
        x1    <= point_x;
        z1    <= point_z;
        ypart <= ypart + {point_y[W-1], point_y};
      end
    end
  end

endmodule

FILE: rtl/ccpt_queue.sv
// ----------------------------------------------------------------------------
// ccpt_queue
// Two-entry queue of triples between the front and the back.
// ----------------------------------------------------------------------------
module ccpt_queue #(
  parameter int QW = 170
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [QW-1:0]           wdata,
  input  logic                    pop,
  output logic [QW-1:0]           rdata,
  output ccpt_pkg::queue_status_t qstat
);
  import ccpt_pkg::*;

  logic [QW-1:0] mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign rdata       = mem[rd_ptr];
  assign qstat.valid = (count != 2'd0);
  assign qstat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

FILE: rtl/ccpt_back.sv
// ----------------------------------------------------------------------------
// ccpt_back
// Works out one triple with a serial multiplier and a serial divider, keeps
// the round sums and holds the result register.
// ----------------------------------------------------------------------------
module ccpt_back #(
  parameter int W  = 24,
  parameter int T  = 3,
  parameter int QW = 7 * W + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ccpt_pkg::queue_status_t qstat,
  input  logic [QW-1:0]           q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [W-1:0]            circle_x,
  output logic [W-1:0]            circle_z,
  output logic                    degenerate,
  output logic                    average_ready,
  output logic [W-1:0]            average_x,
  output logic [W-1:0]            average_y,
  output logic [W-1:0]            average_z
);
  import ccpt_pkg::*;

  localparam int DF  = W + 1;
  localparam int SQ  = 2 * W + 3;
  localparam int DW  = 2 * W + 4;
  localparam int P   = 3 * W + 5;
  localparam int SW  = W + 7;
  localparam int BCW = $clog2(W + 1);
  localparam int DCW = $clog2(P);
  localparam int TW  = $clog2(T + 1);
  localparam logic [P-1:0]         LIM    = P'(64'd1 << 40);
  localparam logic signed [42:0]   SAT_HI = 43'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [42:0]   SAT_LO = -SAT_HI - 43'sd1;

  back_state_t state, state_next;
  mul_step_t   mstep;
  div_step_t   dstep;

  logic [W-1:0]   x0, z0, x1, z1, x2, z2;
  logic [W-1:0]   base_x, base_z;
  logic [W+1:0]   ys_in, ys;
  logic [DF-1:0]  bx, bz, cx, cz;
  logic [SQ-1:0]  b2, c2;
  logic [DW-1:0]  d;
  logic [P-1:0]   nx, nz;
  logic [P-1:0]   mcand, acc, acc_sum, prod;
  logic [DF-1:0]  mplier;
  logic [BCW-1:0] bitcnt;
  logic           mul_last;
  logic [DF-1:0]  mpl_sel;
  logic [P-1:0]   mcd_sel;

  logic [P-1:0]   dnum, num_sel;
  logic [DW-1:0]  drem, ddiv, den_sel;
  logic           dneg;
  logic [DCW-1:0] dcnt;
  logic           div_last;
  logic [DW:0]    trial;
  logic           ge;
  logic [40:0]    qmag;
  logic signed [42:0] qval, base, total;
  logic [W-1:0]   post;

  logic [W-1:0]   cxo, czo, ax, ay, az;
  logic           degen, avg_rdy;
  logic [SW-1:0]  sum_x, sum_z, sum_y;
  logic [TW-1:0]  tdone;

  function automatic logic signed [42:0] cx_base(input logic [W-1:0] v);
    cx_base = {{(43-W){v[W-1]}}, v};
  endfunction

  assign {x0, z0, x1, z1, x2, z2, ys_in} = q_data;

  // serial signed multiply: top multiplier bit has negative weight
  assign mul_last = (bitcnt == BCW'(W));
  assign acc_sum  = mul_last ? acc - mcand : acc + mcand;
  assign prod     = mplier[0] ? acc_sum : acc;

  always_comb begin
    case (mstep)
      MS_BXBX: begin mpl_sel = bx; mcd_sel = {{(P-DF){bx[DF-1]}}, bx}; end
      MS_BZBZ: begin mpl_sel = bz; mcd_sel = {{(P-DF){bz[DF-1]}}, bz}; end
      MS_CXCX: begin mpl_sel = cx; mcd_sel = {{(P-DF){cx[DF-1]}}, cx}; end
      MS_CZCZ: begin mpl_sel = cz; mcd_sel = {{(P-DF){cz[DF-1]}}, cz}; end
      MS_CZBX: begin mpl_sel = cz; mcd_sel = {{(P-DF){bx[DF-1]}}, bx}; end
      MS_CXBZ: begin mpl_sel = cx; mcd_sel = {{(P-DF){bz[DF-1]}}, bz}; end
      MS_CZB2: begin mpl_sel = cz; mcd_sel = {{(P-SQ){b2[SQ-1]}}, b2}; end
      MS_BZC2: begin mpl_sel = bz; mcd_sel = {{(P-SQ){c2[SQ-1]}}, c2}; end
      MS_BXC2: begin mpl_sel = bx; mcd_sel = {{(P-SQ){c2[SQ-1]}}, c2}; end
      MS_CXB2: begin mpl_sel = cx; mcd_sel = {{(P-SQ){b2[SQ-1]}}, b2}; end
      default: begin mpl_sel = '0; mcd_sel = '0; end
    endcase
  end

  always_comb begin
    case (dstep)
      DS_CX:   begin num_sel = nx; den_sel = d; end
      DS_CZ:   begin num_sel = nz; den_sel = d; end
      DS_AX:   begin num_sel = {{(P-SW){sum_x[SW-1]}}, sum_x}; den_sel = DW'(T); end
      DS_AZ:   begin num_sel = {{(P-SW){sum_z[SW-1]}}, sum_z}; den_sel = DW'(T); end
      DS_AY:   begin num_sel = {{(P-SW){sum_y[SW-1]}}, sum_y}; den_sel = DW'(3 * T); end
      default: begin num_sel = '0; den_sel = '0; end
    endcase
  end

  // restoring divide on magnitudes, quotient shifts into dnum
  assign div_last = (dcnt == DCW'(P - 1));
  assign trial    = {drem, dnum[P-1]};
  assign ge       = (trial >= {1'b0, ddiv});

  assign qmag  = (dnum > LIM) ? LIM[40:0] : dnum[40:0];
  assign qval  = dneg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
  assign base  = (dstep == DS_CX) ? 43'($signed(cx_base(base_x))) :
                 (dstep == DS_CZ) ? 43'($signed(cx_base(base_z))) : 43'sd0;
  assign total = qval + base;
  assign post  = (total > SAT_HI) ? SAT_HI[W-1:0] :
                 (total < SAT_LO) ? SAT_LO[W-1:0] : total[W-1:0];

  assign q_pop = (state == ST_IDLE) && qstat.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (qstat.valid) state_next = ST_MLOAD;
      ST_MLOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          if (mstep != MS_CXB2)  state_next = ST_MLOAD;
          else if (d == '0)      state_next = ST_ACC;
          else                   state_next = ST_DLOAD;
        end
      end
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV:   if (div_last) state_next = ST_DPOST;
      ST_DPOST: begin
        if (dstep == DS_CZ)      state_next = ST_ACC;
        else if (dstep == DS_AY) state_next = ST_OUT;
        else                     state_next = ST_DLOAD;
      end
      ST_ACC:   state_next = (tdone == TW'(T - 1)) ? ST_DLOAD : ST_OUT;
      ST_OUT:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tdone     <= '0;
      sum_x     <= '0;
      sum_z     <= '0;
      sum_y     <= '0;
    end else begin
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ACC) begin
        sum_x <= sum_x + {{(SW-W){cxo[W-1]}}, cxo};
        sum_z <= sum_z + {{(SW-W){czo[W-1]}}, czo};
        sum_y <= sum_y + {{(SW-W-2){ys[W+1]}}, ys};
        tdone <= (tdone == TW'(T - 1)) ? '0 : tdone + TW'(1);
      end
      if (state == ST_DPOST && dstep == DS_AY) begin
        sum_x <= '0;
        sum_z <= '0;
        sum_y <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (qstat.valid) begin
          bx     <= {x1[W-1], x1} - {x0[W-1], x0};
          bz     <= {z1[W-1], z1} - {z0[W-1], z0};
          cx     <= {x2[W-1], x2} - {x0[W-1], x0};
          cz     <= {z2[W-1], z2} - {z0[W-1], z0};
          base_x <= x0;
          base_z <= z0;
          ys     <= ys_in;
          mstep  <= MS_BXBX;
        end
      end
      ST_MLOAD: begin
        mcand  <= mcd_sel;
        mplier <= mpl_sel;
        acc    <= '0;
        bitcnt <= '0;
      end
      ST_MUL: begin
        if (mplier[0]) acc <= acc_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        bitcnt <= bitcnt + BCW'(1);
        if (mul_last) begin
          case (mstep)
            MS_BXBX: b2 <= prod[SQ-1:0];
            MS_BZBZ: b2 <= b2 + prod[SQ-1:0];
            MS_CXCX: c2 <= prod[SQ-1:0];
            MS_CZCZ: c2 <= c2 + prod[SQ-1:0];
            MS_CZBX: d  <= prod[DW-1:0];
            MS_CXBZ: d  <= (d - prod[DW-1:0]) << 1;
            MS_CZB2: nx <= prod;
            MS_BZC2: nx <= nx - prod;
            MS_BXC2: nz <= prod;
            MS_CXB2: nz <= nz - prod;
            default: ;
          endcase
          if (mstep != MS_CXB2) begin
            mstep <= mul_step_t'(mstep + 4'd1);
          end else begin
            dstep <= DS_CX;
            degen <= (d == '0);
            if (d == '0) begin
              cxo <= '0;
              czo <= '0;
            end
          end
        end
      end
      ST_DLOAD: begin
        dnum <= num_sel[P-1] ? -num_sel : num_sel;
        ddiv <= den_sel[DW-1] ? -den_sel : den_sel;
        dneg <= num_sel[P-1] ^ den_sel[DW-1];
        drem <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        drem <= ge ? DW'(trial - {1'b0, ddiv}) : trial[DW-1:0];
        dnum <= {dnum[P-2:0], ge};
        dcnt <= dcnt + DCW'(1);
      end
      ST_DPOST: begin
        case (dstep)
          DS_CX: begin cxo <= post; dstep <= DS_CZ; end
          DS_CZ: czo <= post;
          DS_AX: begin ax <= post; dstep <= DS_AZ; end
          DS_AZ: begin az <= post; dstep <= DS_AY; end
          DS_AY: ay <= post;
          default: ;
        endcase
      end
      ST_ACC: begin
        if (tdone == TW'(T - 1)) begin
          avg_rdy <= 1'b1;
          dstep   <= DS_AX;
        end else begin
          avg_rdy <= 1'b0;
          ax      <= '0;
          ay      <= '0;
          az      <= '0;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          circle_x      <= cxo;
          circle_z      <= czo;
          degenerate    <= degen;
          average_ready <= avg_rdy;
          average_x     <= ax;
          average_y     <= ay;
          average_z     <= az;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/circle_center_from_point_triples.sv
// ----------------------------------------------------------------------------
// circle_center_from_point_triples
// Circle centers in the x-z plane from point triples, with round averages.
// ----------------------------------------------------------------------------
// Input channel: one 3D point per beat (point_x, point_y, point_z, Q8.16),
// accepted on in_valid high with in_stall low. Every third point closes a
// triple and gives one result beat on the output channel: the circle center,
// the degenerate flag and, on the last triple of a round of TRIPLES triples,
// the average center and average height.
// A triple is worked out by the serial multiplier (ten products, each with
// its load) and the restoring divider (one quotient per divide, with load
// and saturation). A collinear triple skips the two divides; the last
// triple of a round adds three divides for the averages.
// A two-triple queue sits between point intake and the arithmetic, so points
// keep being taken while a triple is worked on and while a result waits.
// The output register holds its beat while out_stall is high; work then
// backs up into the queue and finally stalls the input.
// Reset clears the triple position, the round count and the sums; the block
// takes points in the first cycle after reset.
// ----------------------------------------------------------------------------
module circle_center_from_point_triples #(
  parameter int TRIPLES     = ccpt_pkg::TRIPLES_DEF,
  parameter int COORD_WIDTH = ccpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] point_x,
  input  logic [COORD_WIDTH-1:0] point_y,
  input  logic [COORD_WIDTH-1:0] point_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] circle_x,
  output logic [COORD_WIDTH-1:0] circle_z,
  output logic                   degenerate,
  output logic                   average_ready,
  output logic [COORD_WIDTH-1:0] average_x,
  output logic [COORD_WIDTH-1:0] average_y,
  output logic [COORD_WIDTH-1:0] average_z
);
  import ccpt_pkg::*;

  localparam int QW = 7 * COORD_WIDTH + 2;

  queue_status_t qstat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  ccpt_front #(.W(COORD_WIDTH), .QW(QW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .qstat    (qstat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  ccpt_queue #(.QW(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  ccpt_back #(.W(COORD_WIDTH), .T(TRIPLES), .QW(QW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .circle_x      (circle_x),
    .circle_z      (circle_z),
    .degenerate    (degenerate),
    .average_ready (average_ready),
    .average_x     (average_x),
    .average_y     (average_y),
    .average_z     (average_z)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("triple pushed into a full queue");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> circle_x == '0 && circle_z == '0)
    else $error("collinear triple with nonzero center");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !average_ready |->
      average_x == '0 && average_y == '0 && average_z == '0)
    else $error("averages set outside the last triple of a round");
`endif

endmodule
